>>> rtl/voice_slot_allocator_top_macros.svh
// Assertion macros for the voice slot allocator.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef VOICE_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define VOICE_SLOT_ALLOCATOR_TOP_MACROS_SVH

// Check that a condition implies a property in the same cycle.
`define VSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a property in the next cycle.
`define VSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/vsa_pkg.sv
// Shared types and constants of the voice slot allocator.
// No dependencies.
package vsa_pkg;

  localparam int NumSlots = 64;
  localparam int SlotW    = 6;
  localparam int CntW     = 7;

  typedef enum logic [2:0] {
    OP_PLAY,
    OP_STOP_SND,
    OP_STOP_ENT,
    OP_FINISH,
    OP_STOP_MUS,
    OP_NOP
  } op_e;

  // input mode codes
  localparam logic [2:0] MODE_PLAY     = 3'd0;
  localparam logic [2:0] MODE_STOP_SND = 3'd1;
  localparam logic [2:0] MODE_STOP_ENT = 3'd2;
  localparam logic [2:0] MODE_FINISH   = 3'd3;
  localparam logic [2:0] MODE_STOP_MUS = 3'd4;

  localparam logic [1:0] KIND_GRANT   = 2'd0;
  localparam logic [1:0] KIND_REFUSE  = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [2:0] RSN_NONE     = 3'd0;
  localparam logic [2:0] RSN_DISABLED = 3'd1;
  localparam logic [2:0] RSN_CULLED   = 3'd2;
  localparam logic [2:0] RSN_LOW_PRIO = 3'd3;
  localparam logic [2:0] RSN_FULL     = 3'd4;

  localparam logic [2:0] CFG_ENABLE   = 3'd0;
  localparam logic [2:0] CFG_MUTE     = 3'd1;
  localparam logic [2:0] CFG_MAX      = 3'd2;
  localparam logic [2:0] CFG_LOW_MASK = 3'd3;
  localparam logic [2:0] CFG_MUS_MASK = 3'd4;

  typedef struct packed {
    logic        sound_enabled;
    logic        muted;
    logic [6:0]  max_active;
    logic [15:0] low_priority_mask;
    logic [15:0] music_mask;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic        id_ok;
    logic [7:0]  sound_id;
    logic [15:0] flags;
    logic [31:0] entity_id;
    logic [7:0]  sound_type;
    logic        clear_all_types;
    logic        too_far;
    logic [5:0]  slot_id;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  sound;
    logic [15:0] flags;
    logic [31:0] entity;
    logic [7:0]  stype;
  } voice_t;

endpackage

>>> rtl/vsa_front.sv
// Front end: accepts command words, decodes the mode and queues them.
// Depends on vsa_pkg.
module vsa_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     mode_i,
  input  logic [7:0]     sound_id_i,
  input  logic           id_valid_i,
  input  logic [15:0]    flags_i,
  input  logic [31:0]    entity_id_i,
  input  logic [7:0]     sound_type_i,
  input  logic           clear_all_types_i,
  input  logic           too_far_i,
  input  logic [5:0]     slot_id_i,
  output logic           cmd_valid_o,
  output vsa_pkg::cmd_t  cmd_o,
  input  logic           cmd_pop_i
);

  vsa_pkg::cmd_t cmd_in;
  vsa_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  always_comb begin
    cmd_in.sound_id        = sound_id_i;
    cmd_in.id_ok           = id_valid_i;
    cmd_in.flags           = flags_i;
    cmd_in.entity_id       = entity_id_i;
    cmd_in.sound_type      = sound_type_i;
    cmd_in.clear_all_types = clear_all_types_i;
    cmd_in.too_far         = too_far_i;
    cmd_in.slot_id         = slot_id_i;
    case (mode_i)
      vsa_pkg::MODE_PLAY:     cmd_in.op = vsa_pkg::OP_PLAY;
      vsa_pkg::MODE_STOP_SND: cmd_in.op = vsa_pkg::OP_STOP_SND;
      vsa_pkg::MODE_STOP_ENT: cmd_in.op = vsa_pkg::OP_STOP_ENT;
      vsa_pkg::MODE_FINISH:   cmd_in.op = vsa_pkg::OP_FINISH;
      vsa_pkg::MODE_STOP_MUS: cmd_in.op = vsa_pkg::OP_STOP_MUS;
      default:                cmd_in.op = vsa_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/vsa_back.sv
// Back end: slot pool, active list, voice stores and the command sequencer.
// Depends on vsa_pkg and voice_slot_allocator_top_macros.svh.
`include "voice_slot_allocator_top_macros.svh"

module vsa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vsa_pkg::cfg_t  cfg_i,
  input  logic           cmd_valid_i,
  input  vsa_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [5:0]     slot_o,
  output logic [2:0]     refuse_reason_o,
  output logic           last_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PWR  = 4'd1;
  localparam logic [3:0] ST_FRD  = 4'd2;
  localparam logic [3:0] ST_FREL = 4'd3;
  localparam logic [3:0] ST_SRD  = 4'd4;
  localparam logic [3:0] ST_SVM  = 4'd5;
  localparam logic [3:0] ST_SCHK = 4'd6;
  localparam logic [3:0] ST_DONE = 4'd7;

  localparam logic [6:0] Full = 7'(vsa_pkg::NumSlots);

  logic [3:0]    st_q, st_d;
  vsa_pkg::cmd_t cmd_q;
  logic [6:0]    ac_q, fc_q, i_q, n_q;
  logic [63:0]   in_list_q;
  logic [63:0]   fs_vld_q;

  // memories
  vsa_pkg::voice_t vmem [vsa_pkg::NumSlots];
  logic [5:0]      alist [vsa_pkg::NumSlots];
  logic [5:0]      pmem [vsa_pkg::NumSlots];
  logic [5:0]      fmem [vsa_pkg::NumSlots];

  vsa_pkg::voice_t vm_rd_q;
  logic [5:0]      al_rd0_q, al_rd1_q, pos_rd_q, fs_rd_q;
  logic            fs_rdv_q;
  logic [5:0]      al_ra0, pos_ra, fs_ra, ac_m1;

  // pending result
  logic       pend_vld_q;
  logic [1:0] pend_kind_q;
  logic [5:0] pend_slot_q;
  logic [2:0] pend_rsn_q;

  logic       out_vld_q, out_last_q;
  logic [1:0] out_kind_q;
  logic [5:0] out_slot_q;
  logic [2:0] out_rsn_q;

  logic       can_emit, hit, rel_en, grant_en;
  logic [2:0] play_rsn;
  logic [5:0] rel_idx, gslot;

  assign can_emit = !out_vld_q || out_ready_i;
  assign ac_m1    = 6'(ac_q - 7'd1);
  assign al_ra0   = (st_q == ST_FRD) ? pos_rd_q : i_q[5:0];
  assign pos_ra   = (st_q == ST_IDLE) ? cmd_i.slot_id : cmd_q.slot_id;
  assign fs_ra    = 6'(fc_q - 7'd1);
  assign rel_idx  = (st_q == ST_FREL) ? pos_rd_q : i_q[5:0];
  // an entry never pushed still holds its reset slot number, 63 - index
  assign gslot    = fs_rdv_q ? fs_rd_q : ~fs_ra;
  assign grant_en = (st_q == ST_PWR);

  always_comb begin
    case (cmd_q.op)
      vsa_pkg::OP_STOP_SND: hit = (vm_rd_q.sound == cmd_q.sound_id) &&
                                  (vm_rd_q.flags == cmd_q.flags);
      vsa_pkg::OP_STOP_ENT: hit = (vm_rd_q.entity == cmd_q.entity_id) &&
                                  ((vm_rd_q.stype == cmd_q.sound_type) ||
                                   cmd_q.clear_all_types);
      vsa_pkg::OP_STOP_MUS: hit = ((vm_rd_q.flags & cfg_i.music_mask) == 16'd0);
      default:              hit = 1'b0;
    endcase
  end

  always_comb begin
    if (!cfg_i.sound_enabled || cfg_i.muted || !cmd_i.id_ok) begin
      play_rsn = vsa_pkg::RSN_DISABLED;
    end else if (cmd_i.too_far) begin
      play_rsn = vsa_pkg::RSN_CULLED;
    end else if (((cmd_i.flags & cfg_i.low_priority_mask) != 16'd0) &&
                 (ac_q >= {1'b0, cfg_i.max_active[6:1]})) begin
      play_rsn = vsa_pkg::RSN_LOW_PRIO;
    end else if ((ac_q >= cfg_i.max_active) || (fc_q == 7'd0)) begin
      play_rsn = vsa_pkg::RSN_FULL;
    end else begin
      play_rsn = vsa_pkg::RSN_NONE;
    end
  end

  assign rel_en = (st_q == ST_FREL) ||
                  ((st_q == ST_SCHK) && hit && (!pend_vld_q || can_emit));
  assign cmd_pop_o = (st_q == ST_IDLE) && cmd_valid_i;

  // voice store
  always_ff @(posedge clk_i) begin
    if (grant_en) begin
      vmem[gslot] <= '{sound: cmd_q.sound_id, flags: cmd_q.flags,
                       entity: cmd_q.entity_id, stype: cmd_q.sound_type};
    end
    vm_rd_q <= vmem[al_rd0_q];
  end

  // active list, two read ports
  always_ff @(posedge clk_i) begin
    if (grant_en) begin
      alist[ac_q[5:0]] <= gslot;
    end else if (rel_en) begin
      alist[rel_idx] <= al_rd1_q;
    end
    al_rd0_q <= alist[al_ra0];
    al_rd1_q <= alist[ac_m1];
  end

  // list positions
  always_ff @(posedge clk_i) begin
    if (grant_en) begin
      pmem[gslot] <= ac_q[5:0];
    end else if (rel_en) begin
      pmem[al_rd1_q] <= rel_idx;
    end
    pos_rd_q <= pmem[pos_ra];
  end

  // free stack
  always_ff @(posedge clk_i) begin
    if (rel_en && (fc_q < Full)) begin
      fmem[fc_q[5:0]] <= al_rd0_q;
    end
    fs_rd_q <= fmem[fs_ra];
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            vsa_pkg::OP_PLAY: begin
              st_d = (play_rsn == vsa_pkg::RSN_NONE) ? ST_PWR : ST_DONE;
            end
            vsa_pkg::OP_FINISH: begin
              st_d = in_list_q[cmd_i.slot_id] ? ST_FRD : ST_DONE;
            end
            vsa_pkg::OP_STOP_SND: begin
              st_d = (cfg_i.sound_enabled && cmd_i.id_ok) ? ST_SRD : ST_DONE;
            end
            vsa_pkg::OP_STOP_ENT, vsa_pkg::OP_STOP_MUS: st_d = ST_SRD;
            default: st_d = ST_DONE;
          endcase
        end
      end
      ST_PWR:  st_d = ST_DONE;
      ST_FRD:  st_d = ({1'b0, pos_rd_q} < ac_q) ? ST_FREL : ST_DONE;
      ST_FREL: st_d = ST_DONE;
      ST_SRD:  st_d = ((i_q < ac_q) && (n_q < Full)) ? ST_SVM : ST_DONE;
      ST_SVM:  st_d = ST_SCHK;
      ST_SCHK: begin
        if (!hit || rel_en) st_d = ST_SRD;
      end
      ST_DONE: begin
        if (can_emit) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      ac_q       <= 7'd0;
      fc_q       <= Full;
      i_q        <= 7'd0;
      n_q        <= 7'd0;
      in_list_q  <= '0;
      fs_vld_q   <= '0;
      fs_rdv_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      fs_rdv_q <= fs_vld_q[fs_ra];
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;

      if (cmd_pop_o) begin
        i_q <= 7'd0;
        n_q <= 7'd0;
        pend_vld_q <= (cmd_i.op == vsa_pkg::OP_PLAY) &&
                      (play_rsn != vsa_pkg::RSN_NONE);
      end

      if (grant_en) begin
        in_list_q[gslot] <= 1'b1;
        ac_q       <= ac_q + 7'd1;
        fc_q       <= fc_q - 7'd1;
        pend_vld_q <= 1'b1;
      end

      if (st_q == ST_SCHK && !hit) i_q <= i_q + 7'd1;

      if (rel_en) begin
        // emit the previous release, hold this one until the next release or the scan ends
        if (pend_vld_q) out_vld_q <= 1'b1;
        in_list_q[al_rd0_q] <= 1'b0;
        if (fc_q < Full) begin
          fs_vld_q[fc_q[5:0]] <= 1'b1;
          fc_q <= fc_q + 7'd1;
        end
        ac_q       <= ac_q - 7'd1;
        n_q        <= n_q + 7'd1;
        pend_vld_q <= 1'b1;
      end

      if (st_q == ST_DONE && can_emit) begin
        out_vld_q  <= 1'b1;
        pend_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q       <= cmd_i;
      pend_kind_q <= vsa_pkg::KIND_REFUSE;
      pend_slot_q <= 6'd0;
      pend_rsn_q  <= play_rsn;
    end
    if (grant_en) begin
      pend_kind_q <= vsa_pkg::KIND_GRANT;
      pend_slot_q <= gslot;
      pend_rsn_q  <= vsa_pkg::RSN_NONE;
    end
    // hold the output word unless a pending release moves into it
    if (rel_en && pend_vld_q) begin
      out_kind_q  <= pend_kind_q;
      out_slot_q  <= pend_slot_q;
      out_rsn_q   <= pend_rsn_q;
      out_last_q  <= 1'b0;
    end
    if (rel_en) begin
      pend_kind_q <= vsa_pkg::KIND_RELEASE;
      pend_slot_q <= al_rd0_q;
      pend_rsn_q  <= vsa_pkg::RSN_NONE;
    end
    if (st_q == ST_DONE && can_emit) begin
      out_kind_q <= pend_vld_q ? pend_kind_q : vsa_pkg::KIND_NONE;
      out_slot_q <= pend_vld_q ? pend_slot_q : 6'd0;
      out_rsn_q  <= pend_vld_q ? pend_rsn_q : vsa_pkg::RSN_NONE;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = out_kind_q;
  assign slot_o          = out_slot_q;
  assign refuse_reason_o = out_rsn_q;
  assign last_o          = out_last_q;

  `VSA_ASSERT_IMP(a_count_sum, 1'b1, ({1'b0, ac_q} + {1'b0, fc_q}) == 8'd64, "slot count lost")
  `VSA_ASSERT_IMP(a_list_pop, 1'b1, $countones(in_list_q) == ac_q, "active list count mismatch")
  `VSA_ASSERT_IMP(a_grant_lim, grant_en, ac_q < cfg_i.max_active, "grant above active limit")
  `VSA_ASSERT_NXT(a_rel_dec, rel_en, ac_q == $past(ac_q) - 7'd1, "release did not shrink list")

endmodule

>>> rtl/voice_slot_allocator_top.sv
// Voice slot allocator, top level: configuration registers, front end and back end.
// Depends on vsa_pkg, vsa_front and vsa_back.
//
// Usage: commands enter on in_valid_i/in_ready_o, one word per handshake, and
// are queued two deep. Each command gives one or more result words on
// out_valid_o/out_ready_i; last_o marks the final word of a command.
// A play request goes through pop, grant write and result; a refused one skips
// the grant write. A slot-finished command goes through pop, position read,
// release and result. A stop command walks the active list, reading each entry
// and its voice from the single-port voice store, then checking it for a match.
// A released slot's result goes out when the next release is found or the
// scan ends, so the receiver sees releases in list order.
// Reset empties the active list, fills the free stack with all slots (slot 0
// on top) and loads the register defaults; no clearing pass is needed.
// When the receiver stalls, the sequencer holds on its next result and the
// queue fills, then in_ready_o drops. Write configuration only while idle.
module voice_slot_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  sound_id_i,
  input  logic        id_valid_i,
  input  logic [15:0] flags_i,
  input  logic [31:0] entity_id_i,
  input  logic [7:0]  sound_type_i,
  input  logic        clear_all_types_i,
  input  logic        too_far_i,
  input  logic [5:0]  slot_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [5:0]  slot_o,
  output logic [2:0]  refuse_reason_o,
  output logic        last_o
);

  vsa_pkg::cfg_t cfg_q;
  vsa_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sound_enabled     <= 1'b0;
      cfg_q.muted             <= 1'b0;
      cfg_q.max_active        <= 7'd64;
      cfg_q.low_priority_mask <= 16'd0;
      cfg_q.music_mask        <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vsa_pkg::CFG_ENABLE:   cfg_q.sound_enabled     <= cfg_wdata_i[0];
        vsa_pkg::CFG_MUTE:     cfg_q.muted             <= cfg_wdata_i[0];
        vsa_pkg::CFG_MAX:      cfg_q.max_active        <= cfg_wdata_i[6:0];
        vsa_pkg::CFG_LOW_MASK: cfg_q.low_priority_mask <= cfg_wdata_i;
        vsa_pkg::CFG_MUS_MASK: cfg_q.music_mask        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  vsa_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .sound_id_i        (sound_id_i),
    .id_valid_i        (id_valid_i),
    .flags_i           (flags_i),
    .entity_id_i       (entity_id_i),
    .sound_type_i      (sound_type_i),
    .clear_all_types_i (clear_all_types_i),
    .too_far_i         (too_far_i),
    .slot_id_i         (slot_id_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_pop_i         (cmd_pop)
  );

  vsa_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .slot_o          (slot_o),
    .refuse_reason_o (refuse_reason_o),
    .last_o          (last_o)
  );

endmodule
